>>> src/smcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcd_pkg - shared definitions for the sensor matrix change detector
// Field widths, stream packing widths, reset values and the job handed from
// the row update stage to the event emitter.
// ----------------------------------------------------------------------------
package smcd_pkg;

    // default matrix size
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;

    // field widths
    localparam int ROW_W   = 3;
    localparam int LEVEL_W = 8;
    localparam int FILE_W  = 3;
    localparam int RANK_W  = 4;
    localparam int SEQ_W   = 32;

    // stream data widths (whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    // event counter value after reset
    localparam logic [SEQ_W-1:0] SEQ_RESET = 32'd1;

    // scan kinds carried in tuser
    localparam logic KIND_PRIME = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    // one row's worth of change events
    typedef struct packed {
        logic [LEVEL_W-1:0] mask;   // changed columns
        logic [LEVEL_W-1:0] now;    // new occupancy of the row
        logic [RANK_W-1:0]  rank;   // rank number of the row
    } t_em_job;

endpackage

>>> src/smcd_occ_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcd_occ_mem - occupancy memory
// One word per row, one bit per column. Single write port, single read port
// with registered read data. Per-row valid bits make unwritten rows read as
// empty after reset.
// ----------------------------------------------------------------------------
module smcd_occ_mem #(
    parameter int DEPTH = smcd_pkg::ROWS_DEF,
    parameter int WIDTH = smcd_pkg::COLS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_valid;
    logic [WIDTH-1:0] r_rd_data;

    // row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_wr_en) begin
            r_row_valid[i_wr_addr] <= 1'b1;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_row_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/smcd_event_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcd_event_emit - change event emitter
// Holds a row's changed-column mask and sends one event per cycle while tready
// is high, lowest column first, tagging each with the global sequence number.
// ----------------------------------------------------------------------------
module smcd_event_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  smcd_pkg::t_em_job                 i_job,
    output logic                              o_job_ready,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: file_index[2:0], rank_number[6:3], occupied[7],
    //        sequence_number[39:8]
    output logic [smcd_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    logic [smcd_pkg::LEVEL_W-1:0] r_mask;
    logic [smcd_pkg::LEVEL_W-1:0] n_mask;
    logic [smcd_pkg::LEVEL_W-1:0] r_now;
    logic [smcd_pkg::RANK_W-1:0]  r_rank;
    logic [smcd_pkg::SEQ_W-1:0]   r_seq;
    logic [smcd_pkg::LEVEL_W-1:0] low_bit;
    logic [smcd_pkg::FILE_W-1:0]  file_idx;
    logic                         is_last;
    logic                         out_accept;
    logic                         job_load;

    // lowest pending column
    assign low_bit = r_mask & (~r_mask + smcd_pkg::LEVEL_W'(1));

    always_comb begin
        file_idx = '0;
        for (int j = smcd_pkg::LEVEL_W - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                file_idx = smcd_pkg::FILE_W'(j);
            end
        end
    end

    assign is_last    = ((r_mask & ~low_bit) == '0);
    assign out_accept = o_m_axis_tvalid && i_m_axis_tready;
    assign o_job_ready = (r_mask == '0) || (out_accept && is_last);
    assign job_load   = i_job_valid && o_job_ready;

    // pending mask update
    always_comb begin
        n_mask = r_mask;
        if (job_load) begin
            n_mask = i_job.mask;
        end else if (out_accept) begin
            n_mask = r_mask & ~low_bit;
        end
    end

    // control state and sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_seq  <= smcd_pkg::SEQ_RESET;
        end else begin
            r_mask <= n_mask;
            if (out_accept) begin
                r_seq <= r_seq + smcd_pkg::SEQ_W'(1);
            end
        end
    end

    // row payload
    always_ff @(posedge i_clk) begin
        if (job_load) begin
            r_now  <= i_job.now;
            r_rank <= i_job.rank;
        end
    end

    assign o_m_axis_tvalid = (r_mask != '0);
    assign o_m_axis_tlast  = is_last;
    assign o_m_axis_tdata  = {r_seq, |(r_now & low_bit), r_rank, file_idx};

endmodule

>>> src/sensor_matrix_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_matrix_change_detector - occupancy change detector for a sensor grid
// Input stream: one scanned row per request. tdata carries row_index and the
// active-low column levels, tuser the kind (priming scan or normal scan).
// A priming request only stores the row. A normal scan emits one event per
// changed square, lowest column first, on the output stream; tlast marks the
// last event of the row. Rows at or above ROWS are accepted and dropped.
// A request is registered in the update stage, then in the emitter's mask.
// Throughput: one request per cycle while the output is ready and rows cause
// no more than one event each; a row with several changes holds the emitter
// until its last event is taken, and the input stalls once the row after it
// waits to hand over its events. Occupancy lives in a registered-read memory;
// a back-to-back read of the row just written uses a forwarding register.
// Reset: all squares read as empty and the sequence counter restarts at 1.
// A stall on the output holds the current event and, once the update stage
// is full, deasserts the input tready; no event is lost or repeated.
// ----------------------------------------------------------------------------
module sensor_matrix_change_detector #(
    parameter int ROWS    = smcd_pkg::ROWS_DEF,
    parameter int COLUMNS = smcd_pkg::COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: row_index[2:0], column_levels[10:3], zero padding[15:11]
    input  logic [smcd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: kind[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: file_index[2:0], rank_number[6:3], occupied[7],
    //        sequence_number[39:8]
    output logic [smcd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: last_event
    output logic                           o_m_axis_tlast
);

    localparam int MemRows  = (ROWS < (1 << smcd_pkg::ROW_W)) ? ROWS
                                                               : (1 << smcd_pkg::ROW_W);
    localparam int ColsUsed = (COLUMNS < smcd_pkg::LEVEL_W) ? COLUMNS : smcd_pkg::LEVEL_W;
    localparam int AddrW    = (MemRows > 1) ? $clog2(MemRows) : 1;
    localparam logic [smcd_pkg::LEVEL_W-1:0] ColMask =
        smcd_pkg::LEVEL_W'((1 << ColsUsed) - 1);

    // input fields
    logic [smcd_pkg::ROW_W-1:0]   s_row;
    logic [smcd_pkg::LEVEL_W-1:0] s_levels;
    logic [smcd_pkg::LEVEL_W-1:0] s_now;
    logic [smcd_pkg::RANK_W-1:0]  s_rank;
    logic [AddrW-1:0]             s_addr;
    logic                         s_accept;
    logic                         s_in_range;
    logic                         s_take;

    // update stage
    logic                         r_b_valid;
    logic                         r_b_kind;
    logic [AddrW-1:0]             r_b_addr;
    logic [smcd_pkg::LEVEL_W-1:0] r_b_now;
    logic [smcd_pkg::RANK_W-1:0]  r_b_rank;
    logic                         r_b_fwd;
    logic [ColsUsed-1:0]          r_fwd_data;
    logic [ColsUsed-1:0]          rd_data;
    logic [smcd_pkg::LEVEL_W-1:0] prev_row;
    logic [smcd_pkg::LEVEL_W-1:0] diff;
    logic                         b_emit;
    logic                         b_adv;
    logic                         em_ready;
    smcd_pkg::t_em_job            job;

    // decode the request
    assign s_row      = i_s_axis_tdata[smcd_pkg::ROW_W-1:0];
    assign s_levels   = i_s_axis_tdata[smcd_pkg::ROW_W +: smcd_pkg::LEVEL_W];
    assign s_now      = ~s_levels & ColMask;
    assign s_rank     = smcd_pkg::RANK_W'(ROWS - int'(s_row));
    assign s_addr     = AddrW'(s_row);
    assign s_in_range = (int'(s_row) < ROWS);
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign s_take     = s_accept && s_in_range;

    assign o_s_axis_tready = !r_b_valid || b_adv;

    // occupancy storage
    smcd_occ_mem #(
        .DEPTH (MemRows),
        .WIDTH (ColsUsed),
        .AW    (AddrW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_take),
        .i_rd_addr (s_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (b_adv),
        .i_wr_addr (r_b_addr),
        .i_wr_data (r_b_now[ColsUsed-1:0])
    );

    // compare against stored row, forwarding the write made at the read edge
    assign prev_row = smcd_pkg::LEVEL_W'(r_b_fwd ? r_fwd_data : rd_data);
    assign diff     = (prev_row ^ r_b_now) & ColMask;
    assign b_emit   = (r_b_kind == smcd_pkg::KIND_SCAN) && (diff != '0);
    assign b_adv    = r_b_valid && (!b_emit || em_ready);

    assign job.mask = diff;
    assign job.now  = r_b_now;
    assign job.rank = r_b_rank;

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_fwd   <= 1'b0;
        end else if (s_take) begin
            r_b_valid <= 1'b1;
            r_b_fwd   <= b_adv && (r_b_addr == s_addr);
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
            r_b_fwd   <= 1'b0;
        end
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_b_kind   <= i_s_axis_tuser;
            r_b_addr   <= s_addr;
            r_b_now    <= s_now;
            r_b_rank   <= s_rank;
            r_fwd_data <= r_b_now[ColsUsed-1:0];
        end
    end

    // event output
    smcd_event_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (r_b_valid && b_emit),
        .i_job           (job),
        .o_job_ready     (em_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
